[design/spq_pkg.sv]
`default_nettype none
package spq_pkg;

	localparam int SPQ_DEPTH = 16;

	typedef enum logic {
		OP_ENQ = 1'b0,
		OP_DEQ = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		op_t         operation;
		logic [63:0] record_tag;
		logic [7:0]  record_age;
		logic [3:0]  record_priority;
	} req_word_t;

	typedef struct packed {
		status_t     status;
		logic        out_valid;
		logic [63:0] out_tag;
		logic [7:0]  out_age;
		logic [3:0]  out_priority;
	} rsp_word_t;

	// One stored record.
	typedef struct packed {
		logic [63:0] tag;
		logic [7:0]  age;
		logic [3:0]  prio;
	} rec_t;

	// Broadcast command to every cell of the chain.
	typedef struct packed {
		logic enq;
		logic deq;
	} cmd_t;

endpackage
`default_nettype wire

[design/spq_stream_if.sv]
`default_nettype none
interface spq_stream_if #(parameter type word_t = logic);
	logic  valid;
	logic  ready;
	word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[design/spq_cell.sv]
`default_nettype none
module spq_cell import spq_pkg::*; (
	input  wire  logic clk,
	input  wire  cmd_t cmd,
	input  wire  rec_t new_rec,
	input  wire  rec_t left_rec,
	input  wire  logic left_keep,
	input  wire  rec_t right_rec,
	input  wire  logic occupied,
	output rec_t rec,
	output logic keep
);

	rec_t rec_q;

	// A cell keeps its record on insert when it holds one that is at least as
	// urgent as the new one; this keeps equal priorities in arrival order.
	assign keep = occupied && (rec_q.prio <= new_rec.prio);
	assign rec = rec_q;

	always_ff @(posedge clk) begin
		if (cmd.enq) begin
			if (!keep) begin
				rec_q <= left_keep ? new_rec : left_rec;
			end
		end else if (cmd.deq) begin
			rec_q <= right_rec;
		end
	end

endmodule
`default_nettype wire

[design/stable_priority_queue.sv]
// Stable priority queue built as a chain of sorted shift cells.
// A result word is registered and appears in the cycle after its request word is accepted.
// One request per cycle while results are taken; each cell then keeps or shifts.
// A result word that is not taken holds back the input; a new request enters no
// earlier than the cycle in which the waiting result word is taken.
// Reset clears the entry count and the output valid; cell contents are not cleared.
`default_nettype none
module stable_priority_queue import spq_pkg::*; #(
	parameter int QUEUE_DEPTH = SPQ_DEPTH
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	spq_stream_if.sink   req,
	spq_stream_if.source rsp
);

	localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [COUNT_W-1:0] count_q;
	rsp_word_t          rsp_q;
	logic               rsp_valid_q;

	logic               accept;
	logic               full;
	logic               empty;
	cmd_t               cmd;
	rec_t               new_rec;
	rsp_word_t          rsp_d;

	rec_t               cell_rec [QUEUE_DEPTH];
	logic               cell_keep [QUEUE_DEPTH];

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign full      = (count_q == COUNT_W'(QUEUE_DEPTH));
	assign empty     = (count_q == '0);

	assign new_rec.tag  = req.data.record_tag;
	assign new_rec.age  = req.data.record_age;
	assign new_rec.prio = req.data.record_priority;

	assign cmd.enq = accept && (req.data.operation == OP_ENQ) && !full;
	assign cmd.deq = accept && (req.data.operation == OP_DEQ) && !empty;

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		rec_t left_rec;
		logic left_keep;
		rec_t right_rec;

		if (i == 0) begin : g_head
			assign left_rec  = new_rec;
			assign left_keep = 1'b1;
		end else begin : g_body
			assign left_rec  = cell_rec[i-1];
			assign left_keep = cell_keep[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign right_rec = '0;
		end else begin : g_inner
			assign right_rec = cell_rec[i+1];
		end

		spq_cell u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.new_rec   (new_rec),
			.left_rec  (left_rec),
			.left_keep (left_keep),
			.right_rec (right_rec),
			.occupied  (count_q > COUNT_W'(i)),
			.rec       (cell_rec[i]),
			.keep      (cell_keep[i])
		);
	end

	always_comb begin
		rsp_d = '0;
		rsp_d.status = ST_DONE;
		if (req.data.operation == OP_ENQ) begin
			if (full) begin
				rsp_d.status = ST_FULL;
			end
		end else if (empty) begin
			rsp_d.status = ST_EMPTY;
		end else begin
			rsp_d.out_valid    = 1'b1;
			rsp_d.out_tag      = cell_rec[0].tag;
			rsp_d.out_age      = cell_rec[0].age;
			rsp_d.out_priority = cell_rec[0].prio;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.enq) begin
				count_q <= count_q + COUNT_W'(1);
			end else if (cmd.deq) begin
				count_q <= count_q - COUNT_W'(1);
			end
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

endmodule
`default_nettype wire

[design/spq_checker.sv]
`default_nettype none
module spq_checker import spq_pkg::*; (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      req_valid,
	input wire logic      req_ready,
	input wire logic      rsp_valid,
	input wire logic      rsp_ready,
	input wire rsp_word_t rsp_data
);

	// A result word that is not taken stays in place.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("result word changed while stalled");

	// Every accepted request produces a result word in the next cycle.
	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> rsp_valid)
		else $error("accepted request gave no result word");

	// The block can take a request whenever its output register is free.
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("input stalled with an empty output register");

	// A presented record always comes with a done status.
	a_valid_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.out_valid |-> rsp_data.status == ST_DONE)
		else $error("record presented with an error status");

	// Empty and full results carry no record.
	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_data.status == ST_EMPTY || rsp_data.status == ST_FULL)
		|-> !rsp_data.out_valid && rsp_data.out_tag == '0 && rsp_data.out_age == '0
		&& rsp_data.out_priority == '0)
		else $error("error status carries record fields");

endmodule

bind stable_priority_queue spq_checker u_spq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);
`default_nettype wire

[dv/stable_priority_queue_tb.sv]
`timescale 1ns / 1ps
module stable_priority_queue_tb;
	import spq_pkg::*;

	localparam int HALF_PERIOD = 6;
	localparam int CYCLE_LIMIT = 200000;
	localparam int SHOW_LIMIT  = 10;
	localparam int IDLE_PCT    = 11;

	logic clk;
	logic arst_n;

	spq_stream_if #(.word_t(req_word_t)) req_if ();
	spq_stream_if #(.word_t(rsp_word_t)) rsp_if ();

	stable_priority_queue dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	req_word_t pending_words[$];
	rsp_word_t expected_words[$];
	rec_t      held_records[$];

	bit steady;
	int words_sent;
	int words_accepted;
	int cycles;
	int mismatches;
	int results_checked;
	int enq_count;
	int full_count;
	int deq_count;
	int empty_count;

	always begin
		clk = 1'b1;
		#HALF_PERIOD;
		clk = 1'b0;
		#HALF_PERIOD;
	end

	// Computes the result of one request and updates the sorted record list.
	function automatic rsp_word_t queue_step(req_word_t w);
		rsp_word_t r;
		rec_t      rec;
		int        pos;
		r = '0;
		r.status = ST_DONE;
		if (w.operation == OP_ENQ) begin
			enq_count++;
			if (held_records.size() >= SPQ_DEPTH) begin
				r.status = ST_FULL;
				full_count++;
			end else begin
				rec.tag  = w.record_tag;
				rec.age  = w.record_age;
				rec.prio = w.record_priority;
				pos = 0;
				while (pos < held_records.size() && held_records[pos].prio <= rec.prio)
					pos++;
				held_records.insert(pos, rec);
			end
		end else begin
			deq_count++;
			if (held_records.size() == 0) begin
				r.status = ST_EMPTY;
				empty_count++;
			end else begin
				rec = held_records.pop_front();
				r.out_valid    = 1'b1;
				r.out_tag      = rec.tag;
				r.out_age      = rec.age;
				r.out_priority = rec.prio;
			end
		end
		return r;
	endfunction

	function automatic req_word_t make_word(op_t op, logic [3:0] prio);
		req_word_t w;
		w.operation       = op;
		w.record_tag      = {$urandom(), $urandom()};
		w.record_age      = 8'($urandom_range(255, 0));
		w.record_priority = prio;
		return w;
	endfunction

	// Random words in runs that lean toward filling, draining or mixing,
	// so the full and empty edges are reached over and over.
	task automatic add_random_words(int n);
		int enq_pct;
		int spread;
		logic [3:0] prio;
		logic [3:0] fixed_prio;
		for (int i = 0; i < n; i++) begin
			if (i % 40 == 0) begin
				case ($urandom_range(2, 0))
					0: enq_pct = 20;
					1: enq_pct = 50;
					default: enq_pct = 85;
				endcase
				spread = $urandom_range(2, 0);
				fixed_prio = 4'($urandom_range(15, 0));
			end
			case (spread)
				0: prio = 4'($urandom_range(3, 0));
				1: prio = fixed_prio;
				default: prio = 4'($urandom_range(15, 0));
			endcase
			if ($urandom_range(99, 0) < enq_pct)
				pending_words.push_back(make_word(OP_ENQ, prio));
			else
				pending_words.push_back(make_word(OP_DEQ, prio));
		end
	endtask

	task automatic wait_drained();
		while (pending_words.size() != 0 || words_accepted != words_sent ||
				expected_words.size() != 0)
			@(posedge clk);
	endtask

	// Driver: a word stays on the bus until it has been taken.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!req_if.valid || words_accepted == words_sent) begin
				if (pending_words.size() != 0 &&
						(steady || $urandom_range(99, 0) >= IDLE_PCT)) begin
					req_if.data  <= pending_words.pop_front();
					req_if.valid <= 1'b1;
					words_sent++;
				end else begin
					req_if.valid <= 1'b0;
				end
			end
			rsp_if.ready <= steady || ($urandom_range(99, 0) >= IDLE_PCT);
		end
	end

	// Monitor: predicts on every accepted request, checks every accepted result.
	always @(posedge clk) begin
		rsp_word_t got;
		rsp_word_t want;
		if (arst_n) begin
			if (req_if.valid && req_if.ready) begin
				expected_words.push_back(queue_step(req_if.data));
				words_accepted++;
			end
			if (rsp_if.valid && rsp_if.ready) begin
				got = rsp_if.data;
				if (expected_words.size() == 0) begin
					mismatches++;
					if (mismatches <= SHOW_LIMIT)
						$display("[%0t] result word with nothing pending: %p", $realtime, got);
				end else begin
					want = expected_words.pop_front();
					results_checked++;
					if (got.status !== want.status || got.out_valid !== want.out_valid ||
							got.out_tag !== want.out_tag || got.out_age !== want.out_age ||
							got.out_priority !== want.out_priority) begin
						mismatches++;
						if (mismatches <= SHOW_LIMIT) begin
							$display("[%0t] result mismatch", $realtime);
							$display("  expected status=%0d valid=%0d tag=%h age=%0d prio=%0d",
								want.status, want.out_valid, want.out_tag, want.out_age,
								want.out_priority);
							$display("  actual   status=%0d valid=%0d tag=%h age=%0d prio=%0d",
								got.status, got.out_valid, got.out_tag, got.out_age,
								got.out_priority);
						end
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d words still expected", cycles,
				expected_words.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		logic [3:0] fill_prio[16];
		req_word_t w;
		fill_prio = '{4'd15, 4'd0, 4'd7, 4'd7, 4'd15, 4'd0, 4'd3, 4'd12,
			4'd7, 4'd0, 4'd15, 4'd1, 4'd7, 4'd14, 4'd2, 4'd8};
		arst_n       = 1'b0;
		req_if.valid = 1'b0;
		req_if.data  = '0;
		rsp_if.ready = 1'b0;
		steady       = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// Directed: empty dequeue, a fill with ties and head inserts, a refused
		// enqueue, then part of the drain.
		pending_words.push_back(make_word(OP_DEQ, 4'd0));
		for (int i = 0; i < 16; i++) begin
			w = make_word(OP_ENQ, fill_prio[i]);
			if (i == 0) begin
				w.record_tag = '1;
				w.record_age = 8'hff;
			end else if (i == 1) begin
				w.record_tag = '0;
				w.record_age = 8'h00;
			end
			pending_words.push_back(w);
		end
		pending_words.push_back(make_word(OP_ENQ, 4'd0));
		repeat (7) pending_words.push_back(make_word(OP_DEQ, 4'd15));

		// The sender holds back until every result of each phase is in.
		wait_drained();
		add_random_words(300);
		wait_drained();
		steady = 1'b1;
		add_random_words(300);
		wait_drained();
		steady = 1'b0;
		add_random_words(300);
		wait_drained();
		repeat (20) @(posedge clk);

		$display("Checked %0d result words over %0d cycles.", results_checked, cycles);
		$display("Enqueues %0d (%0d refused as full), dequeues %0d (%0d on empty).",
			enq_count, full_count, deq_count, empty_count);
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatching result words", mismatches);
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
